@@ rtl/assert_macros.svh @@
// Assertion macros shared by the substring finder RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset
`define WSF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("wsf assertion failed");
// Check on every clock edge, reset included
`define WSF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("wsf assertion failed");
`else
`define WSF_ASSERT(label, clk, rst, prop)
`define WSF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/wsf_pkg.sv @@
// Shared types and constants for the wildcard substring finder.
// No dependencies; used by every module of the block.
package wsf_pkg;

   // Parameter defaults
   localparam int PatternMaxDefault = 16;
   localparam int OffsetBitsDefault = 16;

   // Depth of the queue between front and back
   localparam int QueueDepth = 4;

   // Pattern byte that matches any text byte (not in position zero)
   localparam logic [7:0] Wildcard = 8'h3F;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_PATTERN_LOW    = 2'd1,
      CSR_PATTERN_HIGH   = 2'd2,
      CSR_MAX_MATCHES    = 2'd3
   } csr_index_type;

   // Kind of a result item
   typedef enum logic {
      KIND_MATCH   = 1'b0,
      KIND_SUMMARY = 1'b1
   } result_kind_type;

   // One classified text byte, passed from front to back
   typedef struct packed {
      logic        hit;     // window matched and start offset in range
      logic [15:0] offset;  // start offset of the window
      logic        last;    // final byte of the text
   } entry_type;

endpackage

@@ rtl/wsf_front.sv @@
// Front end: takes text bytes, keeps the byte history and compares the window.
// Depends on wsf_pkg; feeds classified bytes into wsf_queue.
module wsf_front #(
   parameter int PATTERN_MAX = wsf_pkg::PatternMaxDefault,
   parameter int OFFSET_BITS = wsf_pkg::OffsetBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // text_byte
   input  logic                req_tlast,   // end_of_text
   input  logic [4:0]          pattern_length,
   input  logic [63:0]         pattern_low,
   input  logic [63:0]         pattern_high,
   input  logic                queue_full,
   output logic                push,
   output wsf_pkg::entry_type  entry
);

   localparam int SeenW = OFFSET_BITS + 1;
   localparam int PatW  = 8 * PATTERN_MAX;
   localparam int ShW   = $clog2(PatW);

   logic [7:0]       recent_ff [PATTERN_MAX-1];
   logic [7:0]       recent_in [PATTERN_MAX-1];
   logic [SeenW-1:0] seen_ff, seen_in;

   logic [4:0]             eff_len;
   logic [7:0]             hist [PATTERN_MAX];
   logic [PatW-1:0]        rev_vec, rp_vec;
   logic [ShW-1:0]         shift_bits;
   logic [PATTERN_MAX-1:0] ok;
   logic                   window_match;
   logic                   eligible;
   logic [SeenW-1:0]       start;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // Pattern length clamped to the supported range
   always_comb begin
      if (pattern_length == 5'd0) begin
         eff_len = 5'd1;
      end else if (int'(pattern_length) > PATTERN_MAX) begin
         eff_len = 5'(PATTERN_MAX);
      end else begin
         eff_len = pattern_length;
      end
   end

   // History: position 0 is the incoming byte, higher positions are older
   always_comb begin
      hist[0] = req_tdata;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         hist[j] = recent_ff[j-1];
      end
   end

   // Pattern reversed and aligned so byte j faces history position j
   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (PATTERN_MAX - 1 - j < 8) begin
            rev_vec[8*j +: 8] = pattern_low[8*((PATTERN_MAX - 1 - j) % 8) +: 8];
         end else if (PATTERN_MAX - 1 - j < 16) begin
            rev_vec[8*j +: 8] = pattern_high[8*((PATTERN_MAX - 1 - j) % 8) +: 8];
         end else begin
            rev_vec[8*j +: 8] = 8'h00;
         end
      end
      shift_bits = ShW'(8 * (PATTERN_MAX - int'(eff_len)));
      rp_vec     = rev_vec >> shift_bits;
   end

   // Parallel byte comparators; first pattern byte always compares exactly
   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         ok[j] = (j >= int'(eff_len))
              || ((rp_vec[8*j +: 8] == wsf_pkg::Wildcard) && (j != int'(eff_len) - 1))
              || (rp_vec[8*j +: 8] == hist[j]);
      end
      window_match = &ok;
   end

   // Window position and start offset
   assign eligible = seen_ff >= SeenW'(eff_len - 5'd1);
   assign start    = seen_ff - SeenW'(eff_len - 5'd1);

   always_comb begin
      entry.hit    = window_match && eligible && !start[SeenW-1];
      entry.offset = 16'(start);
      entry.last   = req_tlast;
   end

   // History shift and byte count
   always_comb begin
      recent_in = recent_ff;
      seen_in   = seen_ff;
      if (push) begin
         recent_in[0] = req_tdata;
         for (int i = 1; i < PATTERN_MAX - 1; i++) begin
            recent_in[i] = recent_ff[i-1];
         end
         if (req_tlast) begin
            seen_in = '0;
         end else if (seen_ff != '1) begin
            seen_in = seen_ff + SeenW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      recent_ff <= recent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

@@ rtl/wsf_queue.sv @@
// Short FIFO decoupling the front end from the result sequencer.
// Depends on wsf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wsf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wsf_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output wsf_pkg::entry_type head
);

   localparam int Depth = wsf_pkg::QueueDepth;
   localparam int AddrW = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   wsf_pkg::entry_type store_ff [Depth];
   logic [AddrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   assign full      = count_ff == CntW'(Depth);
   assign not_empty = count_ff != '0;
   assign head      = store_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(Depth - 1)) ? '0 : wr_ptr_ff + AddrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(Depth - 1)) ? '0 : rd_ptr_ff + AddrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `WSF_ASSERT(a_count_bound, clock, reset, count_ff <= CntW'(Depth))
   `WSF_ASSERT(a_no_push_full, clock, reset, full |-> !push)
   `WSF_ASSERT(a_no_pop_empty, clock, reset, !not_empty |-> !pop)

endmodule

@@ rtl/wsf_back.sv @@
// Back end: counts matches, applies the match limit and sequences results.
// Depends on wsf_pkg and assert_macros.svh; drains wsf_queue.
`include "assert_macros.svh"
module wsf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        max_matches,
   input  logic               q_valid,
   input  wsf_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata,  // match_offset, match_count, found, zero pad
   output logic               rsp_tuser,  // result_kind
   output logic               rsp_tlast   // run_last
);

   logic [15:0] match_cnt_ff, match_cnt_in;
   logic        stop_ff, stop_in;

   logic        sum_valid_ff, sum_valid_in;
   logic [15:0] sum_cnt_ff, sum_cnt_in;

   logic                     out_valid_ff, out_valid_in;
   wsf_pkg::result_kind_type out_kind_ff, out_kind_in;
   logic [15:0]              out_off_ff, out_off_in;
   logic [15:0]              out_cnt_ff, out_cnt_in;
   logic                     out_found_ff, out_found_in;
   logic                     out_last_ff, out_last_in;

   logic        out_free;
   logic        stop_now;
   logic        hit_go;
   logic [15:0] cnt_next;

   assign out_free = !out_valid_ff || rsp_tready;
   assign q_pop    = q_valid && !sum_valid_ff && out_free;
   assign stop_now = stop_ff || (match_cnt_ff >= max_matches);
   assign hit_go   = !stop_now && q_head.hit;
   assign cnt_next = match_cnt_ff + 16'(hit_go);

   // Result sequencing: a pending summary goes first, then the next entry
   always_comb begin
      match_cnt_in = match_cnt_ff;
      stop_in      = stop_ff;
      sum_valid_in = sum_valid_ff;
      sum_cnt_in   = sum_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_off_in   = out_off_ff;
      out_cnt_in   = out_cnt_ff;
      out_found_in = out_found_ff;
      out_last_in  = out_last_ff;
      if (sum_valid_ff && out_free) begin
         out_valid_in = 1'b1;
         out_kind_in  = wsf_pkg::KIND_SUMMARY;
         out_off_in   = '0;
         out_cnt_in   = sum_cnt_ff;
         out_found_in = sum_cnt_ff != '0;
         out_last_in  = 1'b1;
         sum_valid_in = 1'b0;
      end else if (q_pop) begin
         if (hit_go) begin
            out_valid_in = 1'b1;
            out_kind_in  = wsf_pkg::KIND_MATCH;
            out_off_in   = q_head.offset;
            out_cnt_in   = cnt_next;
            out_found_in = 1'b1;
            out_last_in  = !q_head.last;
            sum_valid_in = q_head.last;
            sum_cnt_in   = cnt_next;
         end else if (q_head.last) begin
            out_valid_in = 1'b1;
            out_kind_in  = wsf_pkg::KIND_SUMMARY;
            out_off_in   = '0;
            out_cnt_in   = cnt_next;
            out_found_in = cnt_next != '0;
            out_last_in  = 1'b1;
         end
         // Text state: cleared after the final byte
         if (q_head.last) begin
            match_cnt_in = '0;
            stop_in      = 1'b0;
         end else begin
            match_cnt_in = cnt_next;
            stop_in      = stop_now || (cnt_next >= max_matches);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_cnt_ff <= '0;
         stop_ff      <= 1'b0;
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         match_cnt_ff <= match_cnt_in;
         stop_ff      <= stop_in;
         sum_valid_ff <= sum_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_cnt_ff   <= sum_cnt_in;
      out_kind_ff  <= out_kind_in;
      out_off_ff   <= out_off_in;
      out_cnt_ff   <= out_cnt_in;
      out_found_ff <= out_found_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_found_ff, out_cnt_ff, out_off_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   `WSF_ASSERT(a_sum_behind_match, clock, reset,
      sum_valid_ff |-> (out_valid_ff && (out_kind_ff == wsf_pkg::KIND_MATCH)))
   `WSF_ASSERT(a_clear_after_last, clock, reset,
      (q_pop && q_head.last) |=> ((match_cnt_ff == '0) && !stop_ff))
   `WSF_ASSERT(a_match_counted, clock, reset,
      (out_valid_ff && (out_kind_ff == wsf_pkg::KIND_MATCH))
         |-> (out_found_ff && (out_cnt_ff != '0)))

endmodule

@@ rtl/wildcard_substring_finder.sv @@
// Wildcard substring finder, top level: configuration registers and wiring.
// Depends on wsf_pkg, wsf_front, wsf_queue and wsf_back.
//
// Usage: text bytes stream in on req_ (tdata = byte, tlast = final byte of
// the text). Each byte closes one window that is compared in parallel
// against the configured pattern; '?' matches any byte except in pattern
// position zero. Results leave on rsp_: tuser 0 is a match report with the
// start offset, tuser 1 the end-of-text summary with count and found flag;
// tlast marks the last result caused by one input byte.
// Throughput: one byte per cycle while the queue has room. A match on the final
// byte yields two results; the queue is not popped while the summary waits.
// Path: the front end compares the window and writes the queue when the byte
// transfers; the back end then loads its output register from the queue head
// once the output is free, and the result is presented from that register.
// csr_ writes are always accepted and must be issued only while idle.
// Reset clears the text state, the queue and the output; registers return
// to length 1, pattern zero, match limit 16. When rsp_tready is low the
// output holds, the 4-entry queue fills and req_tready drops.
module wildcard_substring_finder #(
   parameter int PATTERN_MAX = wsf_pkg::PatternMaxDefault,
   parameter int OFFSET_BITS = wsf_pkg::OffsetBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   // Text input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_text
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] match_offset, [31:16] match_count, [32] found
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast,   // run_last
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [4:0]  pat_len_ff;
   logic [63:0] pat_low_ff;
   logic [63:0] pat_high_ff;
   logic [15:0] max_matches_ff;

   logic               q_push, q_pop, q_full, q_valid;
   wsf_pkg::entry_type q_in, q_head;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff     <= 5'd1;
         pat_low_ff     <= '0;
         pat_high_ff    <= '0;
         max_matches_ff <= 16'd16;
      end else if (csr_valid && csr_ready) begin
         case (wsf_pkg::csr_index_type'(csr_index))
            wsf_pkg::CSR_PATTERN_LENGTH: pat_len_ff     <= csr_data[4:0];
            wsf_pkg::CSR_PATTERN_LOW:    pat_low_ff     <= csr_data;
            wsf_pkg::CSR_PATTERN_HIGH:   pat_high_ff    <= csr_data;
            wsf_pkg::CSR_MAX_MATCHES:    max_matches_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   wsf_front #(
      .PATTERN_MAX (PATTERN_MAX),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .pattern_length (pat_len_ff),
      .pattern_low    (pat_low_ff),
      .pattern_high   (pat_high_ff),
      .queue_full     (q_full),
      .push           (q_push),
      .entry          (q_in)
   );

   wsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   wsf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .max_matches (max_matches_ff),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ test/substring_match_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the wildcard substring finder: follows csr_ writes and req_
// transfers, predicts match reports and summaries, and checks every rsp_ transfer.
// Depends on wsf_pkg for the register indexes, the result kinds and the wildcard byte.
module substring_match_checker #(
   parameter int PATTERN_MAX = 16,
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_text
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [15:0] match_offset, [31:16] match_count, [32] found
   input  logic        rsp_tuser,   // result_kind
   input  logic        rsp_tlast,   // run_last
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          failures,
   output int          outstanding,
   output int          match_reports,
   output int          text_summaries
);

   localparam longint OffsetLimit = (longint'(1) << OFFSET_BITS) - 1;
   localparam longint SeenLimit   = (longint'(1) << (OFFSET_BITS + 1)) - 1;

   typedef struct packed {
      wsf_pkg::result_kind_type kind;
      logic [15:0]              offset;
      logic [15:0]              count;
      logic                     found;
      logic                     last;
   } search_result_type;

   // Register copies
   logic [4:0]  cfg_length;
   logic [63:0] cfg_low;
   logic [63:0] cfg_high;
   logic [15:0] cfg_limit;

   // Text state: previous bytes (newest first), position, hits so far
   logic [7:0]  history [PATTERN_MAX-1];
   longint      seen;
   int          hits;
   logic        halted;

   search_result_type awaited_results [$];

   function automatic logic [7:0] pattern_byte(int k);
      if (k < 8) return cfg_low[8*k +: 8];
      if (k < 16) return cfg_high[8*(k-8) +: 8];
      return 8'h00;
   endfunction

   // Length in force: zero acts as one, oversize clamps to the window size
   function automatic int active_length();
      int n;
      n = cfg_length;
      if (n == 0) n = 1;
      if (n > PATTERN_MAX) n = PATTERN_MAX;
      return n;
   endfunction

   // Byte k (0 = oldest) of the window that ends at the current byte
   function automatic logic [7:0] window_byte(int k, int len, logic [7:0] cur);
      if (k + 1 >= len) return cur;
      return history[len-2-k];
   endfunction

   // First pattern byte compares exactly, the rest honor the wildcard
   function automatic logic window_hit(int len, logic [7:0] cur);
      int k;
      logic [7:0] p;
      if (pattern_byte(0) != window_byte(0, len, cur)) return 1'b0;
      for (k = 1; k < len; k++) begin
         p = pattern_byte(k);
         if (p != wsf_pkg::Wildcard && p != window_byte(k, len, cur)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void clear_text_state();
      foreach (history[k]) history[k] = 8'h00;
      seen = 0;
      hits = 0;
      halted = 1'b0;
   endfunction

   // One text byte in, zero to two results queued
   function automatic void take_text_byte(logic [7:0] cur, logic eot);
      int k;
      int len;
      longint start;
      logic have_match;
      search_result_type hit_report;
      search_result_type summary;
      len = active_length();
      have_match = 1'b0;
      hit_report = '0;
      summary = '0;
      if (!halted && hits >= cfg_limit) halted = 1'b1;
      if (!halted && seen + 1 >= len) begin
         start = seen + 1 - len;
         if (start <= OffsetLimit && window_hit(len, cur)) begin
            hits++;
            have_match = 1'b1;
            hit_report.kind   = wsf_pkg::KIND_MATCH;
            hit_report.offset = start[15:0];
            hit_report.count  = hits[15:0];
            hit_report.found  = 1'b1;
            hit_report.last   = !eot;
            if (hits >= cfg_limit) halted = 1'b1;
         end
      end
      for (k = PATTERN_MAX - 2; k > 0; k--) history[k] = history[k-1];
      history[0] = cur;
      if (seen < SeenLimit) seen++;
      if (have_match) awaited_results.push_back(hit_report);
      if (eot) begin
         summary.kind   = wsf_pkg::KIND_SUMMARY;
         summary.offset = 16'd0;
         summary.count  = hits[15:0];
         summary.found  = (hits != 0);
         summary.last   = 1'b1;
         awaited_results.push_back(summary);
         clear_text_state();
      end
   endfunction

   function automatic void compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_result();
      search_result_type want;
      if (awaited_results.size() == 0) begin
         $error("unexpected result: kind %0d offset %0d count %0d",
                rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
         failures++;
         return;
      end
      want = awaited_results.pop_front();
      if (want.kind == wsf_pkg::KIND_MATCH) match_reports++;
      else text_summaries++;
      compare_field("result_kind", want.kind, rsp_tuser);
      compare_field("match_offset", want.offset, rsp_tdata[15:0]);
      compare_field("match_count", want.count, rsp_tdata[31:16]);
      compare_field("found", want.found, rsp_tdata[32]);
      compare_field("run_last", want.last, rsp_tlast);
   endfunction

   // Everything is sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      if (reset) begin
         cfg_length = 5'd1;
         cfg_low = 64'd0;
         cfg_high = 64'd0;
         cfg_limit = 16'd16;
         clear_text_state();
         awaited_results.delete();
         failures = 0;
         match_reports = 0;
         text_summaries = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (wsf_pkg::csr_index_type'(csr_index))
               wsf_pkg::CSR_PATTERN_LENGTH: cfg_length = csr_data[4:0];
               wsf_pkg::CSR_PATTERN_LOW:    cfg_low = csr_data;
               wsf_pkg::CSR_PATTERN_HIGH:   cfg_high = csr_data;
               wsf_pkg::CSR_MAX_MATCHES:    cfg_limit = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_text_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      outstanding = awaited_results.size();
   end

endmodule

@@ test/wildcard_substring_finder_test.sv @@
`timescale 1ns / 1ps
// Top of the wildcard substring finder testbench: clock, reset, stimulus and verdict.
// Depends on wsf_pkg, wildcard_substring_finder and substring_match_checker.
module wildcard_substring_finder_test;

   localparam int     HalfPeriod   = 6;
   localparam int     ResetCycles  = 6;
   localparam int     SettleCycles = 8;      // result latency is short, keep a margin
   localparam int     HoldCycles   = 80;     // long receiver hold-off
   localparam int     RandomItems  = 1600;
   localparam longint TimeLimitNs  = 24_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = wsf_pkg::CSR_PATTERN_LENGTH;
   logic [63:0] csr_data = 64'd0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [39:0] rsp_tdata;
   wire         rsp_tuser;
   wire         rsp_tlast;
   wire         csr_ready;

   int failures;
   int outstanding;
   int match_reports;
   int text_summaries;

   // Pattern as the generator sees it, used to plant copies in the text
   logic [7:0] needle [16];
   int         needle_len = 1;

   int bytes_sent = 0;
   int stall_left = 0;
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   bit hold_request = 1'b0;

   wildcard_substring_finder DUT (.*);

   substring_match_checker match_check (.*);

   always #HalfPeriod clock = ~clock;

   initial begin
      #(TimeLimitNs);
      $error("timed out with %0d results outstanding", outstanding);
      $display("== FAIL ==");
      $finish;
   end

   // Mostly short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         stall_left = HoldCycles;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = rx_calm ? 0 : idle_gap();
      end
   end

   // One text byte transfer; starts and ends at a falling edge, tvalid left high
   task automatic push_byte(logic [7:0] b, logic eot);
      int gap;
      gap = tx_calm ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Sender pauses until every expected result is out and the pipe is empty
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_register(wsf_pkg::csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_pattern(logic [4:0] len, logic [63:0] lo, logic [63:0] hi,
                              logic [15:0] limit);
      int k;
      drain_results();
      write_register(wsf_pkg::CSR_PATTERN_LENGTH, {59'd0, len});
      write_register(wsf_pkg::CSR_PATTERN_LOW, lo);
      write_register(wsf_pkg::CSR_PATTERN_HIGH, hi);
      write_register(wsf_pkg::CSR_MAX_MATCHES, {48'd0, limit});
      for (k = 0; k < 8; k++) begin
         needle[k] = lo[8*k +: 8];
         needle[k+8] = hi[8*k +: 8];
      end
      needle_len = (len == 0) ? 1 : (len > 16) ? 16 : len;
   endtask

   // Random setting with the extremes weighted in
   task automatic random_setup();
      int r;
      int k;
      logic [4:0] len;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [15:0] limit;
      logic [7:0] b;
      r = $urandom_range(0, 9);
      if (r < 2) len = 5'd1;
      else if (r < 4) len = 5'd16;
      else if (r == 4) len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
      else len = 5'($urandom_range(2, 15));
      for (k = 0; k < 16; k++) begin
         r = $urandom_range(0, 99);
         if (r < 25) b = wsf_pkg::Wildcard;
         else if (r < 40) b = 8'h00;
         else if (r < 50) b = 8'hFF;
         else if (r < 70) b = 8'($urandom_range(8'h41, 8'h43));
         else b = 8'($urandom_range(0, 255));
         if (k < 8) lo[8*k +: 8] = b;
         else hi[8*(k-8) +: 8] = b;
      end
      r = $urandom_range(0, 9);
      if (r == 0) limit = 16'd0;
      else if (r == 1) limit = 16'd1;
      else if (r == 2) limit = 16'hFFFF;
      else if (r < 7) limit = 16'($urandom_range(2, 6));
      else limit = 16'($urandom_range(0, 65535));
      set_pattern(len, lo, hi, limit);
   endtask

   // Text with planted pattern copies (some cut short) among random and pattern bytes
   task automatic send_text(int n, bit close);
      int i;
      int j;
      int cut;
      logic [7:0] b;
      i = 0;
      while (i < n) begin
         if ($urandom_range(0, 2) == 0) begin
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, needle_len) : needle_len;
            for (j = 0; j < cut && i < n; j++) begin
               b = needle[j];
               if (j > 0 && b == wsf_pkg::Wildcard) b = 8'($urandom_range(0, 255));
               i++;
               push_byte(b, close && i == n);
            end
         end else begin
            if ($urandom_range(0, 1)) b = needle[$urandom_range(0, needle_len - 1)];
            else b = 8'($urandom_range(0, 255));
            i++;
            push_byte(b, close && i == n);
         end
      end
   endtask

   initial begin : stimulus
      int i;
      int goal;
      logic [7:0] b;
      foreach (needle[k]) needle[k] = 8'h00;
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset setting: one-byte pattern 0x00, zero bytes compare exactly
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h3F, 1'b1);
      push_byte(8'h00, 1'b1);   // match and summary from one byte

      // Wildcard in position zero must match exactly
      set_pattern(5'd3, 64'h00_3F_3F, 64'd0, 16'd16);
      push_byte(8'h3F, 1'b0);
      push_byte(8'h3F, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h3F, 1'b0);
      push_byte(8'h77, 1'b0);
      push_byte(8'h00, 1'b1);

      // Full-length pattern, overlapping hits, stop after the first
      set_pattern(5'd16, 64'h3F3F3F3F_3F3F3FA5, 64'hFF3F3F3F_3F3F3F3F, 16'd1);
      for (i = 0; i < 17; i++) begin
         b = (i < 2) ? 8'hA5 : (i >= 15) ? 8'hFF : 8'($urandom_range(0, 255));
         push_byte(b, i == 16);
      end

      // Receiver holds off while every byte hits: output and queue fill up
      set_pattern(5'd1, 64'h5A, 64'd0, 16'hFFFF);
      tx_calm = 1'b1;
      hold_request = 1'b1;
      for (i = 0; i < 24; i++) push_byte(8'h5A, i == 23);
      tx_calm = 1'b0;

      // Random settings and texts; some texts stay open across a setting change
      goal = bytes_sent + RandomItems;
      while (bytes_sent < goal) begin
         random_setup();
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(3, 8)) begin
            send_text(($urandom_range(0, 6) == 0) ? $urandom_range(25, 64)
                                                  : $urandom_range(1, 24), 1'b1);
         end
         if ($urandom_range(0, 5) == 0) send_text($urandom_range(1, 20), 1'b0);
      end
      push_byte(8'($urandom_range(0, 255)), 1'b1);

      drain_results();
      $display("Sent %0d text bytes: directed cases, receiver hold-off, random settings",
               bytes_sent);
      $display("Checked %0d match reports and %0d end-of-text summaries",
               match_reports, text_summaries);
      if (failures == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/wsf_pkg.sv
rtl/wsf_front.sv
rtl/wsf_queue.sv
rtl/wsf_back.sv
rtl/wildcard_substring_finder.sv
test/substring_match_checker.sv
test/wildcard_substring_finder_test.sv
